// File: rtl/alux_pkg.sv
// ----------------------------------------------------------------------------
// alux_pkg
// Shared types, constants and lookup functions for the auto-ranging lux core.
// ----------------------------------------------------------------------------
package alux_pkg;

  // fixed-point format of the lux result
  localparam int unsigned LUX_FRAC_BITS = 4;
  localparam int unsigned LUX_W         = 32;

  // input and register widths
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned LIMIT_W  = 17;
  localparam int unsigned NUM_W    = 20;   // count * 9
  localparam int unsigned CMP_W    = 30;   // limit compare width
  localparam int unsigned CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DARK   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd2;

  // configuration reset values
  localparam logic [COUNT_W-1:0] DARK_RST   = 16'd100;
  localparam logic [COUNT_W-1:0] BRIGHT_RST = 16'd10000;
  localparam logic [LIMIT_W-1:0] LIMIT_RST  = 17'd1000;

  // gain codes
  localparam logic [1:0] GAIN_X1   = 2'd0;
  localparam logic [1:0] GAIN_X2   = 2'd1;
  localparam logic [1:0] GAIN_X1_8 = 2'd2;
  localparam logic [1:0] GAIN_X1_4 = 2'd3;

  // integration time index
  localparam logic [2:0] TIME_MAX = 3'd5;
  localparam logic [2:0] TIME_RST = 3'd2;

  // constant divider: (n + 1250) / 2500, four quotient bits a cycle
  localparam int unsigned DIV_W         = 48;
  localparam int unsigned DIV_BITS      = 4;
  localparam int unsigned DIV_STEPS     = DIV_W / DIV_BITS;
  localparam int unsigned DIV_CNT_W     = $clog2(DIV_STEPS + 1);
  localparam int unsigned REM_W         = 12;
  localparam logic [REM_W:0] DIVISOR    = 13'd2500;
  localparam logic [DIV_W-1:0] DIV_BIAS = 48'd1250;
  localparam logic [CMP_W-1:0] LIMIT_SCALE = 30'd2500;

  // polynomial correction in q24
  localparam logic [4:0] CORR_SHIFT  = 5'd15;
  localparam logic [4:0] PLAIN_SHIFT = 5'(LUX_FRAC_BITS);
  localparam int unsigned ROUND_SH   = 24 - LUX_FRAC_BITS;
  localparam logic [63:0] ROUND_HALF = 64'd1 << (ROUND_SH - 1);
  localparam logic [63:0] MUL_HALF   = 64'h0000_0000_8000_0000;
  localparam int unsigned POLY_STEPS = 4;

  localparam logic signed [63:0] COEF_D4 = 64'sd2977740970497054;
  localparam logic signed [63:0] COEF_D3 = 64'sd354834839629639;
  localparam logic signed [63:0] COEF_D2 = 64'sd23487316891851;
  localparam logic signed [63:0] COEF_D1 = 64'sd2204081009040;

  // controller to datapath commands
  typedef struct packed {
    logic       capture;
    logic       range;
    logic       limit;
    logic       div_start;
    logic       poly_init;
    logic       abs;
    logic       mul_lo;
    logic       mul_hi;
    logic       mul_add;
    logic [1:0] step;
    logic       finish;
    logic       out_load;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic changed;
    logic corr;
    logic div_busy;
  } sts_t;

  // constant added after each horner multiply
  function automatic logic signed [63:0] coef_add(input logic [1:0] step);
    logic signed [63:0] c;
    unique case (step)
      2'd0:    c = -COEF_D3;
      2'd1:    c = COEF_D2;
      2'd2:    c = COEF_D1;
      default: c = 64'sd0;
    endcase
    return c;
  endfunction

  // gain contribution to the resolution exponent
  function automatic logic [2:0] gain_shift(input logic [1:0] g);
    logic [2:0] s;
    unique case (g)
      GAIN_X1:   s = 3'd1;
      GAIN_X2:   s = 3'd0;
      GAIN_X1_8: s = 3'd4;
      default:   s = 3'd3;
    endcase
    return s;
  endfunction

  // sensor code for an integration time index
  function automatic logic [3:0] time_code(input logic [2:0] t);
    logic [3:0] c;
    unique case (t)
      3'd0:    c = 4'hC;
      3'd1:    c = 4'h8;
      3'd2:    c = 4'h0;
      3'd3:    c = 4'h1;
      3'd4:    c = 4'h2;
      default: c = 4'h3;
    endcase
    return c;
  endfunction

  // integration time plus settle margin in ms
  function automatic logic [9:0] wait_time(input logic [2:0] t);
    logic [9:0] w;
    unique case (t)
      3'd0:    w = 10'd35;
      3'd1:    w = 10'd60;
      3'd2:    w = 10'd110;
      3'd3:    w = 10'd210;
      3'd4:    w = 10'd410;
      default: w = 10'd810;
    endcase
    return w;
  endfunction

endpackage

// File: rtl/alux_div.sv
// ----------------------------------------------------------------------------
// alux_div
// Radix-16 restoring divider by the constant 2500 for the lux scaling.
// ----------------------------------------------------------------------------
module alux_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [alux_pkg::DIV_W-1:0] dividend_i,
  output logic                       busy_o,
  output logic [alux_pkg::DIV_W-1:0] quotient_o
);

  logic [alux_pkg::DIV_W-1:0]     quo_q, quo_d;
  logic [alux_pkg::REM_W-1:0]     rem_q, rem_d;
  logic [alux_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;

  // four shift-compare-subtract steps per cycle
  always_comb begin
    logic [alux_pkg::REM_W:0]   r;
    logic [alux_pkg::DIV_W-1:0] q;
    r = {1'b0, rem_q};
    q = quo_q;
    for (int j = 0; j < alux_pkg::DIV_BITS; j++) begin
      r = {r[alux_pkg::REM_W-1:0], q[alux_pkg::DIV_W-1]};
      q = {q[alux_pkg::DIV_W-2:0], 1'b0};
      if (r >= alux_pkg::DIVISOR) begin
        r    = r - alux_pkg::DIVISOR;
        q[0] = 1'b1;
      end
    end
    quo_d = q;
    rem_d = r[alux_pkg::REM_W-1:0];
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= alux_pkg::DIV_CNT_W'(alux_pkg::DIV_STEPS);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_d;
    end
  end

  assign cnt_d = cnt_q - alux_pkg::DIV_CNT_W'(1);

  // quotient and remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o     = (cnt_q != '0);
  assign quotient_o = quo_q;

endmodule

// File: rtl/alux_dp.sv
// ----------------------------------------------------------------------------
// alux_dp
// Datapath: configuration, range state, scaling divider, horner correction
// with one shared 32x32 multiplier, and the output register.
// ----------------------------------------------------------------------------
module alux_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  alux_pkg::cmd_t                 cmd_i,
  output alux_pkg::sts_t                 sts_o,
  input  logic                           cfg_we_i,
  input  logic [alux_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [alux_pkg::LIMIT_W-1:0]   cfg_data_i,
  input  logic [alux_pkg::COUNT_W-1:0]   raw_count_i,
  input  logic                           is_reread_i,
  output logic [alux_pkg::LUX_W-1:0]     lux_value_o,
  output logic                           lux_valid_o,
  output logic [15:0]                    settings_word_o,
  output logic [9:0]                     wait_ms_o,
  output logic [1:0]                     gain_index_o,
  output logic [2:0]                     time_index_o
);

  logic [alux_pkg::COUNT_W-1:0] dark_q, bright_q, count_q;
  logic [alux_pkg::LIMIT_W-1:0] limit_q;
  logic [1:0]                   gain_q, gain_d;
  logic [2:0]                   time_q, time_d, cur_t;
  logic                         reread_q, changed_q, changed_d, corr_q;
  logic [alux_pkg::NUM_W-1:0]   num_q;
  logic [3:0]                   k;
  logic [4:0]                   sh_amt;
  logic [alux_pkg::CMP_W-1:0]   lim_prod, scaled;
  logic [alux_pkg::DIV_W-1:0]   dividend, quotient;
  logic                         div_busy;
  logic [31:0]                  x_q, mul_a;
  logic signed [63:0]           acc_q;
  logic [63:0]                  mag_q, plo_q, r_q, prod, rnd;
  logic                         neg_q;
  logic [alux_pkg::LUX_W-1:0]   lux_q, lux_d;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dark_q   <= alux_pkg::DARK_RST;
      bright_q <= alux_pkg::BRIGHT_RST;
      limit_q  <= alux_pkg::LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        alux_pkg::CFG_DARK:   dark_q   <= cfg_data_i[alux_pkg::COUNT_W-1:0];
        alux_pkg::CFG_BRIGHT: bright_q <= cfg_data_i[alux_pkg::COUNT_W-1:0];
        alux_pkg::CFG_LIMIT:  limit_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cur_t = (time_q > alux_pkg::TIME_MAX) ? alux_pkg::TIME_MAX : time_q;

  // auto-range rule, dark test first
  always_comb begin
    gain_d    = gain_q;
    time_d    = time_q;
    changed_d = 1'b0;
    if (!reread_q) begin
      if (count_q < dark_q) begin
        if (cur_t < alux_pkg::TIME_MAX) begin
          time_d    = cur_t + 3'd1;
          changed_d = 1'b1;
        end else if (gain_q == alux_pkg::GAIN_X1) begin
          gain_d    = alux_pkg::GAIN_X2;
          changed_d = 1'b1;
        end
      end else if (count_q > bright_q) begin
        if (cur_t != 3'd0) begin
          time_d    = cur_t - 3'd1;
          changed_d = 1'b1;
        end else if (gain_q != alux_pkg::GAIN_X1_8 && gain_q != alux_pkg::GAIN_X1_4) begin
          gain_d    = alux_pkg::GAIN_X1_8;
          changed_d = 1'b1;
        end
      end
    end
  end

  // range state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= alux_pkg::GAIN_X1;
      time_q <= alux_pkg::TIME_RST;
    end else if (cmd_i.range) begin
      gain_q <= gain_d;
      time_q <= time_d;
    end
  end

  // resolution exponent and limit test
  assign k        = 4'(alux_pkg::gain_shift(gain_q)) + 4'd5 - 4'(cur_t);
  assign lim_prod = alux_pkg::CMP_W'(limit_q) * alux_pkg::LIMIT_SCALE;
  assign scaled   = alux_pkg::CMP_W'(num_q) << k;

  // divider operand
  assign sh_amt   = 5'(k) + (corr_q ? alux_pkg::CORR_SHIFT : alux_pkg::PLAIN_SHIFT);
  assign dividend = (alux_pkg::DIV_W'(num_q) << sh_amt) + alux_pkg::DIV_BIAS;

  alux_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  // item capture, range flag, correction flag
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      count_q  <= raw_count_i;
      reread_q <= is_reread_i;
      num_q    <= (alux_pkg::NUM_W'(raw_count_i) << 3) + alux_pkg::NUM_W'(raw_count_i);
    end
    if (cmd_i.range) begin
      changed_q <= changed_d;
    end
    if (cmd_i.limit) begin
      corr_q <= (scaled > lim_prod);
    end
  end

  // shared multiplier on one 32-bit half of the magnitude
  assign mul_a = cmd_i.mul_hi ? mag_q[63:32] : mag_q[31:0];
  assign prod  = 64'(mul_a) * 64'(x_q);

  // horner evaluation
  always_ff @(posedge clk_i) begin
    if (cmd_i.poly_init) begin
      acc_q <= alux_pkg::COEF_D4;
      x_q   <= quotient[31:0];
    end
    if (cmd_i.abs) begin
      neg_q <= acc_q[63];
      mag_q <= acc_q[63] ? 64'(-acc_q) : 64'(acc_q);
    end
    if (cmd_i.mul_lo) begin
      plo_q <= prod;
    end
    if (cmd_i.mul_hi) begin
      r_q <= prod + ((plo_q + alux_pkg::MUL_HALF) >> 32);
    end
    if (cmd_i.mul_add) begin
      acc_q <= (neg_q ? -$signed(r_q) : $signed(r_q)) + alux_pkg::coef_add(cmd_i.step);
    end
  end

  // rounding and saturation
  assign rnd = 64'(acc_q) + alux_pkg::ROUND_HALF;

  always_comb begin
    logic [63:0] shifted;
    shifted = rnd >> alux_pkg::ROUND_SH;
    if (corr_q) begin
      if (acc_q <= 64'sd0) begin
        lux_d = '0;
      end else if (shifted[63:alux_pkg::LUX_W] != '0) begin
        lux_d = '1;
      end else begin
        lux_d = shifted[alux_pkg::LUX_W-1:0];
      end
    end else if (quotient[alux_pkg::DIV_W-1:alux_pkg::LUX_W] != '0) begin
      lux_d = '1;
    end else begin
      lux_d = quotient[alux_pkg::LUX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      lux_q <= lux_d;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      lux_value_o     <= changed_q ? '0 : lux_q;
      lux_valid_o     <= !changed_q;
      settings_word_o <= {3'b000, gain_q, 1'b0, alux_pkg::time_code(cur_t), 6'b000000};
      wait_ms_o       <= alux_pkg::wait_time(cur_t);
      gain_index_o    <= gain_q;
      time_index_o    <= cur_t;
    end
  end

  assign sts_o.changed  = changed_q;
  assign sts_o.corr     = corr_q;
  assign sts_o.div_busy = div_busy;

endmodule

// File: rtl/alux_ctrl.sv
// ----------------------------------------------------------------------------
// alux_ctrl
// Sequencer: walks one item through range update, scaling division,
// polynomial correction and hand-off to the output register.
// ----------------------------------------------------------------------------
module alux_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  alux_pkg::sts_t sts_i,
  output alux_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RANGE,
    S_CHECK,
    S_DSTART,
    S_DIV,
    S_ABS,
    S_MLO,
    S_MHI,
    S_ADD,
    S_FIN,
    S_DONE
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] step_q, step_d;
  logic       out_valid_q, out_valid_d;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = (out_valid_q && !out_stall_i) ? 1'b0 : out_valid_q;
    cmd_o       = '0;
    cmd_o.step  = step_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_RANGE;
        end
      end
      S_RANGE: begin
        cmd_o.range = 1'b1;
        state_d     = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.changed) begin
          state_d = S_DONE;
        end else begin
          cmd_o.limit = 1'b1;
          state_d     = S_DSTART;
        end
      end
      S_DSTART: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (!sts_i.div_busy) begin
          if (sts_i.corr) begin
            cmd_o.poly_init = 1'b1;
            step_d          = '0;
            state_d         = S_ABS;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_ABS: begin
        cmd_o.abs = 1'b1;
        state_d   = S_MLO;
      end
      S_MLO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = S_MHI;
      end
      S_MHI: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = S_ADD;
      end
      S_ADD: begin
        cmd_o.mul_add = 1'b1;
        if (step_q == 2'(alux_pkg::POLY_STEPS - 1)) begin
          state_d = S_FIN;
        end else begin
          step_d  = step_q + 2'd1;
          state_d = S_ABS;
        end
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/ambient_light_autorange_lux_core.sv
// ----------------------------------------------------------------------------
// ambient_light_autorange_lux_core
// Auto-ranging lux converter: keeps gain and integration time, steps the
// range on dark or bright counts and turns counts into 28.4 fixed-point lux.
// ----------------------------------------------------------------------------
//  channel   handshake                   payload
//  input     in_valid_i / in_stall_o     raw_count_i, is_reread_i
//  output    out_valid_o / out_stall_i   lux_value_o, lux_valid_o, settings_word_o,
//                                        wait_ms_o, gain_index_o, time_index_o
//  config    cfg_valid_i / cfg_ready_o   cfg_index_i, cfg_data_i
//
//  A discarded item skips the divider; a plain conversion runs the radix-16
//  divider by 2500, and a corrected one adds four horner steps on the one
//  shared 32x32 multiplier. One item is in flight; the next is taken while
//  its result waits in the output register. Reset sets gain x1, time 100 ms
//  and default thresholds.
// ----------------------------------------------------------------------------
module ambient_light_autorange_lux_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [alux_pkg::COUNT_W-1:0]   raw_count_i,
  input  logic                           is_reread_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [alux_pkg::LUX_W-1:0]     lux_value_o,
  output logic                           lux_valid_o,
  output logic [15:0]                    settings_word_o,
  output logic [9:0]                     wait_ms_o,
  output logic [1:0]                     gain_index_o,
  output logic [2:0]                     time_index_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [alux_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [alux_pkg::LIMIT_W-1:0]   cfg_data_i
);

  alux_pkg::cmd_t cmd;
  alux_pkg::sts_t sts;

  // registers are always writable
  assign cfg_ready_o = 1'b1;

  alux_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  alux_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_valid_i & cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .raw_count_i     (raw_count_i),
    .is_reread_i     (is_reread_i),
    .lux_value_o     (lux_value_o),
    .lux_valid_o     (lux_valid_o),
    .settings_word_o (settings_word_o),
    .wait_ms_o       (wait_ms_o),
    .gain_index_o    (gain_index_o),
    .time_index_o    (time_index_o)
  );

endmodule
